### sv/triangle_squish_max_assert.svh
// ---------------------------------------------------------------------------
// triangle_squish_max assertion macros
// shared concurrent assertion forms for the squish block
// ---------------------------------------------------------------------------
`ifndef TRIANGLE_SQUISH_MAX_ASSERT_SVH
`define TRIANGLE_SQUISH_MAX_ASSERT_SVH

// same-cycle implication
`define TSM_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("tsm assertion failed");

// next-cycle implication
`define TSM_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("tsm assertion failed");

`endif

### sv/tsm_pkg.sv
// ---------------------------------------------------------------------------
// tsm_pkg
// types and fixed widths for the triangle squish block
// ---------------------------------------------------------------------------
`default_nettype none

package tsm_pkg;

    localparam int CoordW  = 16;
    localparam int DiffW   = 17;
    localparam int ProdW   = 34;
    localparam int SumW    = 34;
    localparam int DotW    = 35;
    localparam int RootW   = 25;
    localparam int QuotW   = 15;
    localparam int ResW    = 16;
    localparam int NumTerm = 6;
    localparam int DataW   = 144;

    localparam logic [ResW-1:0] ONE_Q15 = 16'h8000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SQRT,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

### sv/tsm_sqrt.sv
// ---------------------------------------------------------------------------
// tsm_sqrt
// bit-serial square root of the squared length scaled by 2^16, one root bit
// per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module tsm_sqrt (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [tsm_pkg::SumW-1:0]  radicand,
    output logic                           done,
    output logic [tsm_pkg::RootW-1:0]      root
);
    import tsm_pkg::*;

    localparam int RadW = 2 * RootW;
    localparam int RemW = RootW + 1;

    logic              busy_reg, busy_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [RadW-1:0]   rad_reg, rad_next;
    logic [RemW-1:0]   rem_reg, rem_next;
    logic [RootW-1:0]  root_reg, root_next;
    logic              done_reg, done_next;

    logic [RemW+1:0]   rem_sh;
    logic [RemW+1:0]   trial;
    logic              ge;

    always_comb
    begin
        rem_sh = {rem_reg, rad_reg[RadW-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        ge     = (rem_sh >= trial);
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rad_next  = {radicand, 16'h0000};
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[RadW-3:0], 2'b00};
            rem_next  = ge ? RemW'(rem_sh - trial) : rem_sh[RemW-1:0];
            root_next = {root_reg[RootW-2:0], ge};
            cnt_next  = cnt_reg + 5'd1;
            if (cnt_reg == 5'(RootW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

### sv/tsm_div.sv
// ---------------------------------------------------------------------------
// tsm_div
// restoring divider for num * 2048 / len, one quotient bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module tsm_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [tsm_pkg::SumW-1:0]  num,
    input  wire logic [tsm_pkg::RootW-1:0] len,
    output logic                           done,
    output logic [tsm_pkg::QuotW-1:0]      quot
);
    import tsm_pkg::*;

    logic              busy_reg, busy_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [RootW-1:0]  r_reg, r_next;
    logic [RootW-1:0]  dsr_reg, dsr_next;
    logic [QuotW-1:0]  dvd_reg, dvd_next;
    logic [QuotW-1:0]  q_reg, q_next;
    logic              done_reg, done_next;

    logic [RootW:0]    t;
    logic              ge;

    always_comb
    begin
        t  = {r_reg, dvd_reg[QuotW-1]};
        ge = (t >= {1'b0, dsr_reg});
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        dsr_next  = dsr_reg;
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            // caller guarantees num >> 4 < len
            r_next    = num[RootW+3:4];
            dsr_next  = len;
            dvd_next  = {num[3:0], 11'b0};
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            r_next   = ge ? RootW'(t - {1'b0, dsr_reg}) : t[RootW-1:0];
            q_next   = {q_reg[QuotW-2:0], ge};
            dvd_next = {dvd_reg[QuotW-2:0], 1'b0};
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'(QuotW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg   <= r_next;
        dsr_reg <= dsr_next;
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

### sv/triangle_squish_max.sv
// ---------------------------------------------------------------------------
// triangle_squish_max
// running maximum of 1 - |area . d| / |d| over the neighbors of a triangle
//
//   channel   dir   payload                                  marks
//   s_axis    in    tdata: 9 x 16 bit centers and area       tuser has_neighbor,
//                                                            tlast last_neighbor
//   m_axis    out   tdata: max_squish Q1.15                  -
//
// a neighbor passes through one shared 17x17 multiplier, then the bit-serial
// square root and then the bit-serial divider; coincident centers skip both
// later units and a dot of one or more skips the divider
// an item with no neighbor goes straight to the done state
// one item at a time; a finished result waits in the output register and a
// last item holds until that register is free
// reset clears the running maximum and the output valid
// ---------------------------------------------------------------------------
`default_nettype none

`include "triangle_squish_max_assert.svh"

module triangle_squish_max (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // current_x, current_y, current_z, neighbor_x, neighbor_y, neighbor_z,
    // area_x, area_y, area_z
    input  wire logic [tsm_pkg::DataW-1:0]  s_axis_tdata,
    // has_neighbor
    input  wire logic                       s_axis_tuser,
    input  wire logic                       s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // max_squish
    output logic [tsm_pkg::ResW-1:0]        m_axis_tdata
);
    import tsm_pkg::*;

    state_t state_reg, state_next;

    logic signed [DiffW-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [DiffW-1:0] ax_reg, ay_reg, az_reg;
    logic                    has_reg, last_reg;
    logic [2:0]              cnt_reg, cnt_next;
    logic signed [ProdW-1:0] prod_reg;
    logic [2:0]              psel_reg;
    logic [SumW-1:0]         s_reg, s_next;
    logic signed [DotW-1:0]  dot_reg, dot_next;
    logic [SumW-1:0]         num;
    logic [ResW-1:0]         max_reg, max_next;
    logic [ResW-1:0]         out_reg, out_next;
    logic                    ovalid_reg, ovalid_next;

    logic signed [DiffW-1:0] mul_a, mul_b;
    logic                    in_acc, out_free;
    logic                    sqrt_start, sqrt_done, div_start, div_done;
    logic [RootW-1:0]        root;
    logic [QuotW-1:0]        quot;
    logic                    too_big;
    logic [ResW-1:0]         squish;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !ovalid_reg || m_axis_tready;
    assign num      = dot_reg[DotW-1] ? SumW'(-dot_reg) : dot_reg[SumW-1:0];
    assign too_big  = ({4'b0, num} >= {9'b0, root, 4'b0});
    assign squish   = ONE_Q15 - {1'b0, quot};

    // shared multiplier operand select
    always_comb
    begin
        case (cnt_reg)
            3'd0:    begin mul_a = dx_reg; mul_b = dx_reg; end
            3'd1:    begin mul_a = dy_reg; mul_b = dy_reg; end
            3'd2:    begin mul_a = dz_reg; mul_b = dz_reg; end
            3'd3:    begin mul_a = ax_reg; mul_b = dx_reg; end
            3'd4:    begin mul_a = ay_reg; mul_b = dy_reg; end
            default: begin mul_a = az_reg; mul_b = dz_reg; end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                    state_next = s_axis_tuser ? ST_MUL : ST_DONE;
            end
            ST_MUL:
            begin
                if (cnt_reg == 3'(NumTerm))
                    state_next = (s_next == '0) ? ST_DONE : ST_SQRT;
            end
            ST_SQRT:
            begin
                if (sqrt_done)
                    state_next = too_big ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!last_reg || out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        s_axis_tready = 1'b0;
        cnt_next      = cnt_reg;
        s_next        = s_reg;
        dot_next      = dot_reg;
        max_next      = max_reg;
        out_next      = out_reg;
        ovalid_next   = ovalid_reg && !m_axis_tready;
        sqrt_start    = 1'b0;
        div_start     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                cnt_next      = '0;
                s_next        = '0;
                dot_next      = '0;
            end
            ST_MUL:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg != 3'd0)
                begin
                    if (psel_reg < 3'd3)
                        s_next = s_reg + SumW'(unsigned'(prod_reg));
                    else
                        dot_next = dot_reg + DotW'(prod_reg);
                end
                if (cnt_reg == 3'(NumTerm) && s_next != '0)
                    sqrt_start = 1'b1;
            end
            ST_SQRT:
            begin
                if (sqrt_done && !too_big)
                    div_start = 1'b1;
            end
            ST_DIV:
            begin
                if (div_done && squish > max_reg)
                    max_next = squish;
            end
            ST_DONE:
            begin
                if (last_reg && out_free)
                begin
                    out_next    = max_reg;
                    ovalid_next = 1'b1;
                    max_next    = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            max_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            max_reg    <= max_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            dx_reg   <= DiffW'(signed'(s_axis_tdata[63:48]))   - DiffW'(signed'(s_axis_tdata[15:0]));
            dy_reg   <= DiffW'(signed'(s_axis_tdata[79:64]))   - DiffW'(signed'(s_axis_tdata[31:16]));
            dz_reg   <= DiffW'(signed'(s_axis_tdata[95:80]))   - DiffW'(signed'(s_axis_tdata[47:32]));
            ax_reg   <= DiffW'(signed'(s_axis_tdata[111:96]));
            ay_reg   <= DiffW'(signed'(s_axis_tdata[127:112]));
            az_reg   <= DiffW'(signed'(s_axis_tdata[143:128]));
            has_reg  <= s_axis_tuser;
            last_reg <= s_axis_tlast;
        end
        prod_reg <= mul_a * mul_b;
        psel_reg <= cnt_reg;
        s_reg    <= s_next;
        dot_reg  <= dot_next;
        out_reg  <= out_next;
    end

    tsm_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (s_next),
        .done     (sqrt_done),
        .root     (root)
    );

    tsm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num),
        .len   (root),
        .done  (div_done),
        .quot  (quot)
    );

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = out_reg;

    `TSM_ASSERT_IMP(a_sqrt_done_state, clk, rst_n, sqrt_done, state_reg == ST_SQRT)
    `TSM_ASSERT_IMP(a_div_done_state, clk, rst_n, div_done, state_reg == ST_DIV && has_reg)
    `TSM_ASSERT_NXT(a_max_cleared, clk, rst_n, state_reg == ST_DONE && last_reg && out_free, max_reg == '0 && m_axis_tvalid)
    `TSM_ASSERT_IMP(a_max_bound, clk, rst_n, 1'b1, max_reg <= ONE_Q15)

endmodule

`default_nettype wire

### bench/squish_checker.sv
// ---------------------------------------------------------------------------
// squish_checker
// watches both stream channels of the squish block, predicts the maximum
// squish of each triangle from the accepted neighbors and compares it with
// every result transaction in order
// ---------------------------------------------------------------------------
`default_nettype none

module squish_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_axis_tvalid,
    input  wire logic                       s_axis_tready,
    input  wire logic [tsm_pkg::DataW-1:0]  s_axis_tdata,
    input  wire logic                       s_axis_tuser,
    input  wire logic                       s_axis_tlast,
    input  wire logic                       m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    input  wire logic [tsm_pkg::ResW-1:0]   m_axis_tdata,
    output int                              fail_count,
    output int                              pending
);

    import tsm_pkg::*;

    logic [ResW-1:0] max_so_far;
    logic [ResW-1:0] expected_max_q[$];

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [ResW-1:0] neighbor_squish(input logic [DataW-1:0] d);
        longint dx, dy, dz, dotp;
        logic [63:0] sq, num, len, dq;
        dx = longint'($signed(d[63:48]))   - longint'($signed(d[15:0]));
        dy = longint'($signed(d[79:64]))   - longint'($signed(d[31:16]));
        dz = longint'($signed(d[95:80]))   - longint'($signed(d[47:32]));
        sq = dx * dx + dy * dy + dz * dz;
        if (sq == 0)
            return '0;
        dotp = longint'($signed(d[111:96])) * dx + longint'($signed(d[127:112])) * dy
             + longint'($signed(d[143:128])) * dz;
        num = (dotp < 0) ? -dotp : dotp;
        len = int_sqrt(sq << 16);
        dq  = (num * 2048) / len;
        if (dq >= 32768)
            return '0;
        return ResW'(32768 - dq);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [ResW-1:0] sq;
        logic [ResW-1:0] exp_v;
        if (!rst_n)
        begin
            max_so_far <= '0;
            fail_count <= 0;
            pending    <= 0;
            expected_max_q.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_max_q.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result transaction: %0d", m_axis_tdata);
                end
                else
                begin
                    exp_v = expected_max_q.pop_front();
                    if (exp_v !== m_axis_tdata)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("max_squish mismatch: expected %0d actual %0d",
                                     exp_v, m_axis_tdata);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                sq = max_so_far;
                if (s_axis_tuser && neighbor_squish(s_axis_tdata) > sq)
                    sq = neighbor_squish(s_axis_tdata);
                if (s_axis_tlast)
                begin
                    expected_max_q.push_back(sq);
                    max_so_far <= '0;
                end
                else
                    max_so_far <= sq;
            end
            pending <= expected_max_q.size();
        end
    end

endmodule

`default_nettype wire

### bench/tb_triangle_squish_max.sv
// ---------------------------------------------------------------------------
// tb_triangle_squish_max
// drives directed and random neighbor runs with random stalls on both sides
// and gives the verdict from the checker's failure count
// ---------------------------------------------------------------------------
`default_nettype none

module tb_triangle_squish_max;

    import tsm_pkg::*;

    localparam int NumRandom = 1900;
    localparam int CycleLimit = 600000;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [DataW-1:0]  s_axis_tdata;
    logic              s_axis_tuser;
    logic              s_axis_tlast;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [ResW-1:0]   m_axis_tdata;
    int                fail_count;
    int                pending;
    int                cycle_count = 0;
    bit                no_idle;

    triangle_squish_max dut (.*);

    squish_checker checker_i (.*);

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge clk)
        m_axis_tready <= no_idle || ($urandom_range(99) >= 31);

    function automatic logic [15:0] rand_coord(input int mode);
        case (mode)
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic [DataW-1:0] d, input logic has, input logic last);
        while (!no_idle && $urandom_range(99) < 31)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= has;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic send_random(input bit is_last);
        logic [DataW-1:0] d;
        int mode;
        mode = $urandom_range(9);
        for (int f = 0; f < 9; f++)
            d[f*16 +: 16] = rand_coord(mode < 3 ? 2 : (mode < 4 ? $urandom_range(3) : 3));
        if (mode == 9)
            d[95:48] = d[47:0];
        send_item(d, $urandom_range(9) != 0, is_last);
    endtask

    initial
    begin
        logic [DataW-1:0] d;
        int n;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        no_idle = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // empty run, no-neighbor closing, coincident centers
        send_item('0, 1'b0, 1'b1);
        send_item('0, 1'b1, 1'b1);
        d = '0;
        d[63:48] = 16'h0100;
        send_item(d, 1'b1, 1'b1);
        d[111:96] = 16'h1000;
        send_item(d, 1'b1, 1'b0);
        d[111:96] = 16'h7fff;
        send_item(d, 1'b1, 1'b0);
        send_item(d, 1'b0, 1'b1);
        // extremes of every field
        for (int f = 0; f < 9; f++)
        begin
            d = {9{16'h7fff}};
            d[f*16 +: 16] = 16'h8000;
            send_item(d, 1'b1, f[0]);
        end
        d = {{3{16'h8000}}, {3{16'h7fff}}, {3{16'h8000}}};
        send_item(d, 1'b1, 1'b0);
        d = {{3{16'h0000}}, {3{16'h8000}}, {3{16'h7fff}}};
        send_item(d, 1'b1, 1'b1);

        n = 0;
        while (n < NumRandom)
        begin
            if (n == 600)
            begin
                s_axis_tvalid <= 1'b0;
                while (pending != 0)
                    @(negedge clk);
                no_idle = 1'b1;
            end
            if (n == 900)
                no_idle = 1'b0;
            for (int k = $urandom_range(5); k >= 0 && n < NumRandom; k--)
            begin
                send_random(k == 0 || n == NumRandom - 1);
                n++;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
